// ===== rtl/tstg_pkg.sv =====
// Shared types and constants of the three-channel square tone generator.
// Depends on nothing; every rtl file refers to it by scoped names.
package tstg_pkg;

	localparam int NUM_REGS     = 14;
	localparam int REG_IDX_W    = 4;
	localparam int MAX_CHANNELS = 3;
	localparam int REG_MIXER    = 7;
	localparam int REG_VOL_BASE = 8;
	localparam int MIX_W        = 13;
	localparam int AMP_W        = 11;
	localparam int PERIOD_W     = 12;
	localparam int CNT_W        = 18;

	// Operation codes of an input transaction
	localparam logic [1:0] OP_INDEX = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic [MIX_W-1:0] mix_sample;
		logic             chan_a_level;
		logic             chan_b_level;
		logic             chan_c_level;
	} out_item_t;

	// Settings that one channel takes from the sound registers
	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [3:0]          volume;
		logic                tone_off;
	} chan_cfg_t;

	// What one channel reports for the current tick
	typedef struct packed {
		logic             level;
		logic [AMP_W-1:0] amp;
	} chan_st_t;

endpackage

// ===== rtl/tstg_chan.sv =====
// One square tone channel: period counter, output level and amplitude.
// Depends on tstg_pkg for the channel setting and status structs.
module tstg_chan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  tstg_pkg::chan_cfg_t cfg,
	output tstg_pkg::chan_st_t  st
);

	logic [tstg_pkg::CNT_W-1:0] cnt_q;
	logic                       level_q;
	logic [tstg_pkg::CNT_W-1:0] reload;
	logic [tstg_pkg::AMP_W-1:0] vol_amp;

	// (period + 1) * 16
	assign reload = {1'b0, ({1'b0, cfg.period} + 13'd1), 4'b0000};

	// 96 * volume = 64 * volume + 32 * volume
	assign vol_amp = {1'b0, cfg.volume, 6'd0} + {2'b00, cfg.volume, 5'd0};

	assign st.level = level_q;
	assign st.amp   = (level_q && !cfg.tone_off) ? vol_amp : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			level_q <= 1'b0;
		end else if (tick && !cfg.tone_off) begin
			if (cnt_q <= tstg_pkg::CNT_W'(1)) begin
				level_q <= ~level_q;
				cnt_q   <= reload;
			end else begin
				cnt_q <= cnt_q - tstg_pkg::CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/three_channel_square_tone_generator.sv =====
// Top level of the three-channel square tone generator.
// Depends on tstg_pkg and instantiates tstg_chan once per channel.
//
// The block takes one input transaction per clock cycle when ready: an index
// write, a data write into the indexed sound register, or a tick. All the work
// of a transaction is done in the cycle it is accepted, straight from the register
// file and the channel counters, and a tick's sample lands in a single output
// register. Input ready is high whenever that register is empty or being drained
// in the same cycle, so with a ready sink the throughput is one transaction per
// cycle and a tick's sample appears in the cycle after acceptance. Index and data
// writes give no output. Register map: 0..5 fine/coarse tone periods of A..C
// (coarse uses bits 3:0), 7 bits 2:0 tone disable of A..C, 8..10 volumes of A..C
// (bits 3:0); registers 6, 11, 12 and 13 are stored only. An index write selects
// the written byte modulo 14. Each enabled channel adds 96 * volume to the
// sample while its level is high, then counts down and toggles, reloading
// (period + 1) * 16, when the count runs out. Channels at or beyond NUM_CHANNELS
// are absent and read as level 0 with no contribution.
module three_channel_square_tone_generator #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tstg_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tstg_pkg::out_item_t out_item
);

	logic [tstg_pkg::REG_IDX_W-1:0] reg_index_q;
	logic [7:0]                     sound_regs_q [tstg_pkg::NUM_REGS];
	logic                           out_valid_q;
	tstg_pkg::out_item_t            out_item_q;

	logic                           in_acc;
	logic                           tick;
	logic [4:0]                     quot;
	logic [7:0]                     rem_raw;
	logic [tstg_pkg::REG_IDX_W-1:0] index_mod;

	tstg_pkg::chan_cfg_t            cfg [tstg_pkg::MAX_CHANNELS];
	tstg_pkg::chan_st_t             st  [tstg_pkg::MAX_CHANNELS];
	logic [tstg_pkg::MIX_W-1:0]     mix;

	// Accept while the output register is free or being emptied this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign tick     = in_acc && (in_item.op == tstg_pkg::OP_TICK);

	// data mod 14: 73/1024 underestimates 1/14 by less than one step over 0..255,
	// so the first remainder is below 28 and one conditional subtract finishes it
	assign quot    = 5'((16'(in_item.data) * 16'd73) >> 10);
	assign rem_raw = in_item.data - (8'(quot) * 8'd14);
	always_comb begin
		if (rem_raw >= 8'(tstg_pkg::NUM_REGS)) begin
			index_mod = tstg_pkg::REG_IDX_W'(rem_raw - 8'(tstg_pkg::NUM_REGS));
		end else begin
			index_mod = tstg_pkg::REG_IDX_W'(rem_raw);
		end
	end

	// Register index and sound register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_index_q <= '0;
			for (int i = 0; i < tstg_pkg::NUM_REGS; i++) begin
				sound_regs_q[i] <= '0;
			end
		end else if (in_acc) begin
			unique case (in_item.op)
				tstg_pkg::OP_INDEX: reg_index_q <= index_mod;
				tstg_pkg::OP_DATA:  sound_regs_q[reg_index_q] <= in_item.data;
				tstg_pkg::OP_TICK,
				tstg_pkg::OP_NONE:  ;
				default:            ;
			endcase
		end
	end

	// Channels: present ones get a counter, absent ones read as silent
	for (genvar ch = 0; ch < tstg_pkg::MAX_CHANNELS; ch++) begin : g_chan
		assign cfg[ch].period   = {sound_regs_q[2*ch+1][3:0], sound_regs_q[2*ch]};
		assign cfg[ch].volume   = sound_regs_q[tstg_pkg::REG_VOL_BASE+ch][3:0];
		assign cfg[ch].tone_off = sound_regs_q[tstg_pkg::REG_MIXER][ch];
		if (ch < NUM_CHANNELS) begin : g_on
			tstg_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.tick   (tick),
				.cfg    (cfg[ch]),
				.st     (st[ch])
			);
		end else begin : g_off
			assign st[ch] = '0;
		end
	end

	// Sum the high, enabled channels
	assign mix = tstg_pkg::MIX_W'(st[0].amp) + tstg_pkg::MIX_W'(st[1].amp)
		+ tstg_pkg::MIX_W'(st[2].amp);

	// Output register: load on a tick, drop once the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			out_item_q.mix_sample   <= mix;
			out_item_q.chan_a_level <= st[0].level;
			out_item_q.chan_b_level <= st[1].level;
			out_item_q.chan_c_level <= st[2].level;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the three-channel square tone generator: random and directed
// register writes and ticks, each tick sample checked against a tone predictor.
// Depends on tstg_pkg and three_channel_square_tone_generator from rtl/.
module tb_top;

	localparam int NUM_CH        = 3;
	localparam int RANDOM_ITEMS  = 1025;
	localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction on either side
	localparam int LONG_HOLD     = 250;   // receiver hold-off used once to back up the block
	localparam int TAIL_CYCLES   = 20;

	// Tone predictor plus the queue of samples still owed by the block.
	class tone_scoreboard;
		tstg_pkg::out_item_t        samples_due[$];
		logic [7:0]                 regs [tstg_pkg::NUM_REGS];
		logic [3:0]                 sel;
		logic [tstg_pkg::CNT_W-1:0] count [tstg_pkg::MAX_CHANNELS];
		logic                       level [tstg_pkg::MAX_CHANNELS];
		int                         mismatches;

		function new();
			sel = '0;
			mismatches = 0;
			foreach (regs[i])
				regs[i] = '0;
			for (int ch = 0; ch < tstg_pkg::MAX_CHANNELS; ch++) begin
				count[ch] = '0;
				level[ch] = 1'b0;
			end
		endfunction

		function int pending();
			return samples_due.size();
		endfunction

		// Advance every present, enabled channel by one tick and build the sample it yields.
		function tstg_pkg::out_item_t predict_tick();
			tstg_pkg::out_item_t s;
			int                  mix;
			int                  per;
			logic                lv [tstg_pkg::MAX_CHANNELS];
			mix = 0;
			s = '0;
			for (int ch = 0; ch < tstg_pkg::MAX_CHANNELS; ch++) begin
				lv[ch] = 1'b0;
				if (ch < NUM_CH) begin
					lv[ch] = level[ch];
					if (!regs[tstg_pkg::REG_MIXER][ch]) begin
						if (level[ch])
							mix += 96 * regs[tstg_pkg::REG_VOL_BASE + ch][3:0];
						if (count[ch] <= 1) begin
							level[ch] = ~level[ch];
							per = int'({regs[2*ch + 1][3:0], regs[2*ch]});
							count[ch] = tstg_pkg::CNT_W'((per + 1) * 16);
						end else begin
							count[ch] = count[ch] - 1'b1;
						end
					end
				end
			end
			s.mix_sample   = mix[tstg_pkg::MIX_W-1:0];
			s.chan_a_level = lv[0];
			s.chan_b_level = lv[1];
			s.chan_c_level = lv[2];
			return s;
		endfunction

		function void absorb_transaction(tstg_pkg::in_item_t it);
			case (it.op)
				tstg_pkg::OP_INDEX: sel = 4'(it.data % tstg_pkg::NUM_REGS);
				tstg_pkg::OP_DATA:  regs[sel] = it.data;
				tstg_pkg::OP_TICK:  samples_due.push_back(predict_tick());
				default:            ;
			endcase
		endfunction

		function void report(string what, tstg_pkg::out_item_t want,
				tstg_pkg::out_item_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%s: expected mix %0d A%0b B%0b C%0b, got mix %0d A%0b B%0b C%0b",
					what, want.mix_sample, want.chan_a_level, want.chan_b_level,
					want.chan_c_level, got.mix_sample, got.chan_a_level,
					got.chan_b_level, got.chan_c_level);
		endfunction

		function void check_sample(tstg_pkg::out_item_t got);
			tstg_pkg::out_item_t want;
			if (samples_due.size() == 0) begin
				report("sample with none pending", '0, got);
			end else begin
				want = samples_due.pop_front();
				if (got.mix_sample !== want.mix_sample ||
						got.chan_a_level !== want.chan_a_level ||
						got.chan_b_level !== want.chan_b_level ||
						got.chan_c_level !== want.chan_c_level)
					report("sample mismatch", want, got);
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	tstg_pkg::in_item_t  in_item   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	tstg_pkg::out_item_t out_item;

	tone_scoreboard sb = new();

	bit hold_req   = 1'b0;  // sender asks the receiver for one long hold-off
	int burst_left = 0;
	int idle_cycles = 0;

	three_channel_square_tone_generator #(
		.NUM_CHANNELS(NUM_CH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always #10 clk = ~clk;

	// Feed every accepted input transaction to the predictor.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.absorb_transaction(in_item);
	end

	// Check every accepted output transaction against the oldest pending sample.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_sample(out_item);
	end

	// Watchdog: end the run if neither side moves a transaction for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Receiver: cycle through stall patterns of random length; honor one long
	// hold-off on request so the output register fills and input ready drops.
	initial begin
		int mode;
		int mode_left;
		int hold_cnt;
		int phase;
		mode = 0;
		mode_left = 0;
		hold_cnt = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				phase++;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (phase % 4 == 0);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Offer one transaction; open a new burst, after a random gap, when the
	// current one is used up. Hold valid and payload until accepted.
	task automatic offer(tstg_pkg::in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic tick();
		tstg_pkg::in_item_t it;
		it.op   = tstg_pkg::OP_TICK;
		it.data = 8'($urandom_range(0, 255));  // ignored by the block; vary it anyway
		offer(it);
	endtask

	task automatic write_reg(logic [7:0] idx_byte, logic [7:0] val);
		tstg_pkg::in_item_t it;
		it.op   = tstg_pkg::OP_INDEX;
		it.data = idx_byte;
		offer(it);
		it.op   = tstg_pkg::OP_DATA;
		it.data = val;
		offer(it);
	endtask

	// Drop valid and wait until every predicted sample has come out.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Pick register data that keeps the tone periods mostly short, so the
	// channels toggle often, with the odd long period and full-range byte.
	function automatic logic [7:0] pick_value(int idx);
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		case (idx)
			0, 2, 4:
				if ($urandom_range(0, 9) != 0)
					v = 8'($urandom_range(0, 40));
			1, 3, 5:
				if ($urandom_range(0, 19) != 0)
					v = {4'($urandom_range(0, 15)), 4'h0};  // high nibble is ignored
			tstg_pkg::REG_MIXER:
				if ($urandom_range(0, 2) != 0)
					v = v & 8'hFA;  // keep A and C enabled most of the time
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		tstg_pkg::in_item_t it;
		int                 sent;
		int                 r;
		int                 idx;
		bit                 paused;
		bit                 held;
		sent = 0;
		paused = 1'b0;
		held = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		tick();                     // counters start at zero: all levels toggle at once
		tick();                     // levels now high but volumes are still zero
		it.op = tstg_pkg::OP_NONE;  // unused op code: nothing happens
		it.data = 8'hFF;
		offer(it);
		write_reg(8'd8, 8'h0F);    // full volume on A
		write_reg(8'd23, 8'hFF);   // index wraps to 9: full volume on B, high bits ignored
		write_reg(8'd10, 8'h0F);   // full volume on C
		write_reg(8'd13, 8'hFF);   // stored-only register
		write_reg(8'd6, 8'h00);
		tick();                     // all three high at full volume: largest mix
		write_reg(8'd7, 8'h07);    // disable every tone: levels hold, mix is zero
		tick();
		write_reg(8'hFF, 8'hFF);   // index wraps to 3: longest coarse period on B
		write_reg(8'd7, 8'hF8);    // re-enable all, unused mixer bits set
		tick();
		tick();
		write_reg(8'd0, 8'hFF);
		write_reg(8'd7, 8'h05);    // only B runs
		tick();
		write_reg(8'd7, 8'h00);
		tick();

		// Random part: mostly ticks and complete index/data pairs, some noise.
		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent >= 400) begin
				paused = 1'b1;
				drain();
			end
			if (!held && sent >= 700) begin
				held = 1'b1;
				hold_req = 1'b1;   // keep offering while the receiver holds off
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				tick();
				sent++;
			end else if (r < 85) begin
				idx = $urandom_range(0, tstg_pkg::NUM_REGS - 1);
				write_reg(8'(idx + tstg_pkg::NUM_REGS *
					$urandom_range(0, (255 - idx) / tstg_pkg::NUM_REGS)),
					pick_value(idx));
				sent += 2;
			end else if (r < 92) begin
				it.op = tstg_pkg::OP_INDEX;
				it.data = 8'($urandom_range(0, 255));
				offer(it);
				sent++;
			end else if (r < 97) begin
				it.op = tstg_pkg::OP_DATA;
				it.data = 8'($urandom_range(0, 255));
				offer(it);
				sent++;
			end else begin
				it.op = tstg_pkg::OP_NONE;   // ignored by the block, not counted
				it.data = 8'($urandom_range(0, 255));
				offer(it);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== three_channel_square_tone_generator.f =====
rtl/tstg_pkg.sv
rtl/tstg_chan.sv
rtl/three_channel_square_tone_generator.sv
test/tb_top.sv
